// ----- src/spq_pkg.sv -----
// shared types and codes for the stable sorted priority queue
// no dependencies; imported by spq_mem, spq_ctrl and the top level
package spq_pkg;

    localparam int unsigned PRIO_W = 4;
    localparam int unsigned TAG_W  = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LIST   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_LISTED   = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_INS_HEAD,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // control part of one result transfer
    typedef struct packed {
        logic    strobe;
        status_t status;
        logic    last;
    } res_ctl_t;

endpackage

// ----- src/spq_mem.sv -----
// entry store: one write port, one read port with registered read data
// depends on spq_pkg for the entry type
module spq_mem
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/spq_ctrl.sv -----
// sequencer for insert, list and clear; drives the entry store and forms results
// depends on spq_pkg; works against the registered read data of spq_mem
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        operation,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TAG_W-1:0]  tag,
    output logic              busy,
    // store port
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output entry_t            mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  entry_t            mem_rdata,
    // result
    output res_ctl_t          res_ctl,
    output logic [CW-1:0]     res_position,
    output logic [PRIO_W-1:0] res_priority,
    output logic [TAG_W-1:0]  res_tag,
    output logic [CW-1:0]     res_occupancy
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;

    logic          accept;
    op_t           op;
    logic          shift_more;
    logic          list_last;
    logic [CW-1:0] idx_ext;

    assign accept     = start && (state_reg == S_IDLE);
    assign op         = op_t'(operation);
    assign busy       = (state_reg != S_IDLE);
    assign idx_ext    = CW'(idx_reg);
    assign shift_more = (mem_rdata.prio > prio_reg);
    assign list_last  = ((idx_ext + CW'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_INSERT:
                        begin
                            if (count_reg != '0 && count_reg != FULL_COUNT)
                            begin
                                state_next = S_INS;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS:
            begin
                if (!shift_more)
                begin
                    state_next = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_INS_HEAD;
                end
            end
            S_INS_HEAD: state_next = S_IDLE;
            S_LIST:
            begin
                if (list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // store accesses, results and datapath updates
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        prio_next      = prio_reg;
        tag_next       = tag_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '{prio: prio_reg, tag: tag_reg};
        mem_re         = 1'b0;
        mem_raddr      = '0;
        res_ctl.strobe = 1'b0;
        res_ctl.status = ST_INSERTED;
        res_ctl.last   = 1'b1;
        res_position   = '0;
        res_priority   = '0;
        res_tag        = '0;
        res_occupancy  = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prio_next = priority_req;
                    tag_next  = tag;
                    case (op)
                        OP_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_ctl.strobe = 1'b1;
                                res_ctl.status = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we         = 1'b1;
                                mem_wdata      = '{prio: priority_req, tag: tag};
                                count_next     = CW'(1);
                                res_ctl.strobe = 1'b1;
                                res_ctl.status = ST_INSERTED;
                                res_position   = CW'(1);
                                res_occupancy  = CW'(1);
                            end
                            else
                            begin
                                // walk back from the tail, shifting higher priorities up
                                mem_re    = 1'b1;
                                mem_raddr = AW'(count_reg - CW'(1));
                                idx_next  = AW'(count_reg - CW'(1));
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_ctl.strobe = 1'b1;
                                res_ctl.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re   = 1'b1;
                                idx_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            res_ctl.strobe = 1'b1;
                            res_ctl.status = ST_CLEARED;
                            res_occupancy  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_ext + CW'(1));
                if (shift_more)
                begin
                    mem_wdata = mem_rdata;
                    if (idx_reg != '0)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg - AW'(1);
                        idx_next  = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    count_next     = count_reg + CW'(1);
                    res_ctl.strobe = 1'b1;
                    res_ctl.status = ST_INSERTED;
                    res_position   = idx_ext + CW'(2);
                    res_occupancy  = count_reg + CW'(1);
                end
            end
            S_INS_HEAD:
            begin
                // every held entry outranked the new one
                mem_we         = 1'b1;
                count_next     = count_reg + CW'(1);
                res_ctl.strobe = 1'b1;
                res_ctl.status = ST_INSERTED;
                res_position   = CW'(1);
                res_occupancy  = count_reg + CW'(1);
            end
            S_LIST:
            begin
                res_ctl.strobe = 1'b1;
                res_ctl.status = ST_LISTED;
                res_ctl.last   = list_last;
                res_position   = idx_ext + CW'(1);
                res_priority   = mem_rdata.prio;
                res_tag        = mem_rdata.tag;
                if (!list_last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- src/stable_sorted_priority_queue_core.sv -----
// Stable sorted priority queue of DEPTH entries (4-bit priority, 32-bit tag), kept in
// ascending priority with equal priorities in arrival order. A command is taken when start
// is high and busy is low; results come on valid and cannot be stalled.
// Timing, all bound by the single read port of the entry store: insert into an empty or a
// full queue, clear and list of an empty queue give their result in the cycle after the
// command; any other insert walks back from the tail, moving each held entry of higher
// priority up one place, then writes the new entry; list of n entries gives one entry per
// cycle. busy drops on the cycle the final result shows.
// Depends on spq_pkg, spq_mem and spq_ctrl.
module stable_sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TAG_W-1:0]  tag,
    output logic              valid,
    output logic [2:0]        status,
    output logic [CW-1:0]     position,
    output logic [PRIO_W-1:0] entry_priority,
    output logic [TAG_W-1:0]  entry_tag,
    output logic [CW-1:0]     occupancy,
    output logic              last
);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    res_ctl_t          res_ctl;
    logic [CW-1:0]     res_position;
    logic [PRIO_W-1:0] res_priority;
    logic [TAG_W-1:0]  res_tag;
    logic [CW-1:0]     res_occupancy;

    logic              valid_reg;
    status_t           status_reg;
    logic              last_reg;
    logic [CW-1:0]     position_reg;
    logic [PRIO_W-1:0] priority_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CW-1:0]     occupancy_reg;

    spq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    spq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .priority_req  (priority_req),
        .tag           (tag),
        .busy          (busy),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .res_ctl       (res_ctl),
        .res_position  (res_position),
        .res_priority  (res_priority),
        .res_tag       (res_tag),
        .res_occupancy (res_occupancy)
    );

    // result register: each transfer is shown for exactly one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= res_ctl.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= res_ctl.status;
        last_reg      <= res_ctl.last;
        position_reg  <= res_position;
        priority_reg  <= res_priority;
        tag_reg       <= res_tag;
        occupancy_reg <= res_occupancy;
    end

    assign valid          = valid_reg;
    assign status         = status_reg;
    assign last           = last_reg;
    assign position       = position_reg;
    assign entry_priority = priority_reg;
    assign entry_tag      = tag_reg;
    assign occupancy      = occupancy_reg;

    // a list transfer that is not the final one leaves the sequencer still walking
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final result while sequencer idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (occupancy <= CW'(DEPTH)))
        else $error("occupancy beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_CLEAR) |=>
            valid && (status == ST_CLEARED) && (occupancy == '0))
        else $error("clear did not report at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == ST_LISTED || status == ST_INSERTED) |->
            (position != '0) && (position <= occupancy))
        else $error("position outside held entries");

endmodule

// ----- tb/tb_stable_sorted_priority_queue_core.sv -----
// self-checking testbench for stable_sorted_priority_queue_core: a directed command table, then
// random insert/list/clear traffic, random gaps; results must match typed rows or the predictor
// depends on spq_pkg and the core under src/
module tb_stable_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int unsigned QDEPTH = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RANDOM_CMDS = 210;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        M_PREDICT,
        M_NONE,
        M_TYPED
    } row_mode_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  position;
        logic [3:0]  prio;
        logic [31:0] tag;
        logic [4:0]  occ;
        logic        last;
    } outcome_t;

    typedef struct {
        row_mode_t   mode;
        logic [1:0]  op;
        logic [3:0]  prio;
        logic [31:0] tag;
        status_t     st;
        logic [4:0]  pos;
        logic [4:0]  occ;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  operation = OP_INSERT;
    logic [3:0]  priority_req = '0;
    logic [31:0] tag = '0;
    logic        busy;
    logic        valid;
    logic [2:0]  status;
    logic [4:0]  position;
    logic [3:0]  entry_priority;
    logic [31:0] entry_tag;
    logic [4:0]  occupancy;
    logic        last;

    // predictor copy of the sorted store
    logic [3:0]  held_prio [QDEPTH];
    logic [31:0] held_tag [QDEPTH];
    int          held_count = 0;

    outcome_t    fresh_results[$];
    outcome_t    awaited_results[$];

    int errors = 0;
    int results_checked = 0;
    int cmds_sent = 0;
    int inserts_done = 0;
    int full_drops = 0;
    int lists_done = 0;
    int clears_done = 0;

    cmd_row_t directed_cmds [24] = '{
        '{M_TYPED,   OP_LIST,   4'd0,  32'h0000_0000, ST_EMPTY,    5'd0, 5'd0},
        '{M_TYPED,   OP_CLEAR,  4'd0,  32'h0000_0000, ST_CLEARED,  5'd0, 5'd0},
        '{M_NONE,    OP_UNUSED, 4'd15, 32'hffff_ffff, ST_EMPTY,    5'd0, 5'd0},
        '{M_TYPED,   OP_INSERT, 4'd15, 32'hffff_ffff, ST_INSERTED, 5'd1, 5'd1},
        '{M_TYPED,   OP_INSERT, 4'd0,  32'h0000_0000, ST_INSERTED, 5'd1, 5'd2},
        '{M_TYPED,   OP_INSERT, 4'd15, 32'h1234_5678, ST_INSERTED, 5'd3, 5'd3},
        '{M_PREDICT, OP_INSERT, 4'd7,  32'ha5a5_a5a5, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd0,  32'h5a5a_5a5a, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_LIST,   4'd9,  32'h0f0f_0f0f, ST_LISTED,   5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd8,  32'h8000_0001, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd8,  32'h8000_0002, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd3,  32'h3333_3333, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd12, 32'hcccc_cccc, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd1,  32'h1111_1111, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd8,  32'h8000_0003, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd14, 32'heeee_eeee, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd5,  32'h5555_5555, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd15, 32'hffff_fffe, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd0,  32'h0000_0001, ST_INSERTED, 5'd0, 5'd0},
        '{M_PREDICT, OP_INSERT, 4'd9,  32'h9999_9999, ST_INSERTED, 5'd0, 5'd0},
        '{M_TYPED,   OP_INSERT, 4'd4,  32'hdead_beef, ST_FULL,     5'd0, 5'd16},
        '{M_PREDICT, OP_LIST,   4'd0,  32'h0000_0000, ST_LISTED,   5'd0, 5'd0},
        '{M_TYPED,   OP_CLEAR,  4'd6,  32'h7777_7777, ST_CLEARED,  5'd0, 5'd0},
        '{M_TYPED,   OP_LIST,   4'd2,  32'h2222_2222, ST_EMPTY,    5'd0, 5'd0}
    };

    stable_sorted_priority_queue_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .priority_req   (priority_req),
        .tag            (tag),
        .valid          (valid),
        .status         (status),
        .position       (position),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .occupancy      (occupancy),
        .last           (last)
    );

    always #5 clk = ~clk;

    // sorted insert after all entries of equal priority, full drop, in-order listing, clear
    function automatic void queue_step(input logic [1:0] op, input logic [3:0] p,
                                       input logic [31:0] t);
        int place;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= QDEPTH)
                begin
                    fresh_results.push_back('{ST_FULL, 5'd0, 4'd0, 32'd0, 5'(held_count), 1'b1});
                end
                else
                begin
                    place = 0;
                    while (place < held_count && held_prio[place] <= p)
                        place++;
                    for (int i = held_count; i > place; i--)
                    begin
                        held_prio[i] = held_prio[i-1];
                        held_tag[i]  = held_tag[i-1];
                    end
                    held_prio[place] = p;
                    held_tag[place]  = t;
                    held_count++;
                    fresh_results.push_back('{ST_INSERTED, 5'(place + 1), 4'd0, 32'd0,
                                              5'(held_count), 1'b1});
                end
            end
            OP_LIST:
            begin
                if (held_count == 0)
                    fresh_results.push_back('{ST_EMPTY, 5'd0, 4'd0, 32'd0, 5'd0, 1'b1});
                for (int i = 0; i < held_count; i++)
                    fresh_results.push_back('{ST_LISTED, 5'(i + 1), held_prio[i], held_tag[i],
                                              5'(held_count), (i + 1 == held_count)});
            end
            OP_CLEAR:
            begin
                held_count = 0;
                fresh_results.push_back('{ST_CLEARED, 5'd0, 4'd0, 32'd0, 5'd0, 1'b1});
            end
            default:
            begin
                // unused code: no state change, no result
            end
        endcase
    endfunction

    // one command transfer; start stays high across back-to-back commands
    task automatic issue(input logic [1:0] op, input logic [3:0] p, input logic [31:0] t,
                         input row_mode_t mode, input outcome_t typed, input int gap);
        start        <= 1'b1;
        operation    <= op;
        priority_req <= p;
        tag          <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        queue_step(op, p, t);
        cmds_sent++;
        if (op == OP_INSERT && fresh_results[0].status == ST_FULL)
            full_drops++;
        else if (op == OP_INSERT)
            inserts_done++;
        else if (op == OP_LIST)
            lists_done++;
        else if (op == OP_CLEAR)
            clears_done++;
        if (mode == M_PREDICT)
            awaited_results = {awaited_results, fresh_results};
        else if (mode == M_TYPED)
            awaited_results.push_back(typed);
        fresh_results.delete();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        outcome_t want;
        if (rst_n && valid === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d pos %0d",
                         $time, status, position);
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                check_field("status", 32'(want.status), 32'(status));
                check_field("position", 32'(want.position), 32'(position));
                check_field("entry_priority", 32'(want.prio), 32'(entry_priority));
                check_field("entry_tag", want.tag, entry_tag);
                check_field("occupancy", 32'(want.occ), 32'(occupancy));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int          sent;
        int          roll;
        bit          burst;
        bit          narrow;
        logic [1:0]  op;
        logic [3:0]  p;
        outcome_t    typed;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[i])
        begin
            typed = '{directed_cmds[i].st, directed_cmds[i].pos, 4'd0, 32'd0,
                      directed_cmds[i].occ, 1'b1};
            issue(directed_cmds[i].op, directed_cmds[i].prio, directed_cmds[i].tag,
                  directed_cmds[i].mode, typed, $urandom_range(0, 13));
        end

        sent = 0;
        burst = 1'b0;
        narrow = 1'b0;
        while (sent < RANDOM_CMDS)
        begin
            // new traffic shape every 40 commands: gapless bursts, crowded priorities
            if (sent % 40 == 0)
            begin
                burst  = ($urandom_range(0, 2) == 0);
                narrow = 1'($urandom_range(0, 1));
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)
                op = OP_INSERT;
            else if (roll < 85)
                op = OP_LIST;
            else if (roll < 93)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            p = narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
            issue(op, p, $urandom(), M_PREDICT, '0, burst ? 0 : $urandom_range(0, 13));
            if (op != OP_UNUSED)
                sent++;
            if (sent == RANDOM_CMDS / 2 && op != OP_UNUSED)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("commands: %0d (inserts %0d, full drops %0d, lists %0d, clears %0d)",
                 cmds_sent, inserts_done, full_drops, lists_done, clears_done);
        $display("results checked: %0d, mismatches: %0d", results_checked, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
